>>> src/rgbg_pkg.sv
// Shared types and constants for the RGB565 gray downscaler.
// No dependencies; used by every module of the block.
package rgbg_pkg;

    localparam int PIX_W   = 16;
    localparam int GRAY_W  = 6;
    localparam int COORD_W = 5;

    // Luma weights (per mille) on the unscaled 5/6/5 channels
    localparam int SUM_W = 16;
    localparam logic [SUM_W-1:0] R_WEIGHT = 16'd299;
    localparam logic [SUM_W-1:0] G_WEIGHT = 16'd587;
    localparam logic [SUM_W-1:0] B_WEIGHT = 16'd114;

    // Divide by 1000 as (sum * RECIP) >> RECIP_SHIFT, exact for sums up to 49784
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP = 17'd67109;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [GRAY_W-1:0] GRAY_MAX = 6'd49;

    // One kept pixel on its way from the front end to the arithmetic back end
    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic               last;
    } sample_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> src/rgbg_front.sv
// Front end: pairs camera bytes into RGB565 pixels and decides which are kept.
// Depends on rgbg_pkg.
module rgbg_front #(
    parameter int SRC_WIDTH  = 160,
    parameter int SRC_HEIGHT = 120,
    parameter int DST_WIDTH  = 24,
    parameter int DST_HEIGHT = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               pixel_byte,
    output logic                     push,
    output rgbg_pkg::sample_t        item
);

    localparam int CW  = $clog2(SRC_WIDTH);
    localparam int RW  = $clog2(SRC_HEIGHT);
    localparam int DCW = $clog2(DST_WIDTH + 1);
    localparam int DRW = $clog2(DST_HEIGHT + 1);
    // DST = Q*SRC + R per axis; drives the ceil(s*DST/SRC) stepping
    localparam int COL_QD = DST_WIDTH / SRC_WIDTH;
    localparam int COL_RD = DST_WIDTH % SRC_WIDTH;
    localparam int ROW_QD = DST_HEIGHT / SRC_HEIGHT;
    localparam int ROW_RD = DST_HEIGHT % SRC_HEIGHT;

    logic           phase_reg, phase_next;
    logic [7:0]     high_reg, high_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [CW-1:0]  col_acc_reg, col_acc_next;
    logic [DCW-1:0] col_c_reg, col_c_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [RW-1:0]  row_acc_reg, row_acc_next;
    logic [DRW-1:0] row_c_reg, row_c_next;

    logic           low_byte;
    logic           col_end, row_end;
    logic           col_borrow, row_borrow;
    logic [DCW-1:0] col_c_step;
    logic [DRW-1:0] row_c_step;
    logic [CW:0]    col_acc_step;
    logic [RW:0]    row_acc_step;
    logic           col_hit, row_hit;

    assign low_byte = accept && phase_reg;
    assign col_end  = (col_reg == CW'(SRC_WIDTH - 1));
    assign row_end  = (row_reg == RW'(SRC_HEIGHT - 1));

    // col_c tracks ceil(col*DST/SRC): the next destination column not yet served
    assign col_borrow   = (col_acc_reg < CW'(COL_RD));
    assign col_c_step   = col_c_reg + DCW'(COL_QD) + DCW'(col_borrow);
    assign col_acc_step = {1'b0, col_acc_reg}
                        + (col_borrow ? (CW+1)'(SRC_WIDTH) : '0)
                        - (CW+1)'(COL_RD);
    assign row_borrow   = (row_acc_reg < RW'(ROW_RD));
    assign row_c_step   = row_c_reg + DRW'(ROW_QD) + DRW'(row_borrow);
    assign row_acc_step = {1'b0, row_acc_reg}
                        + (row_borrow ? (RW+1)'(SRC_HEIGHT) : '0)
                        - (RW+1)'(ROW_RD);

    // A source index is sampled when some destination index maps onto it
    assign col_hit = (col_c_step != col_c_reg) && (col_c_reg < DCW'(DST_WIDTH));
    assign row_hit = (row_c_step != row_c_reg) && (row_c_reg < DRW'(DST_HEIGHT));

    assign push        = low_byte && col_hit && row_hit;
    assign item.pixel  = {high_reg, pixel_byte};
    assign item.dest_x = rgbg_pkg::COORD_W'(col_c_reg);
    assign item.dest_y = rgbg_pkg::COORD_W'(row_c_reg);
    assign item.last   = (col_c_step == DCW'(DST_WIDTH)) && (row_c_step == DRW'(DST_HEIGHT));

    always_comb
    begin
        phase_next   = phase_reg;
        high_next    = high_reg;
        col_next     = col_reg;
        col_acc_next = col_acc_reg;
        col_c_next   = col_c_reg;
        row_next     = row_reg;
        row_acc_next = row_acc_reg;
        row_c_next   = row_c_reg;
        if (accept && !phase_reg)
        begin
            phase_next = 1'b1;
            high_next  = pixel_byte;
        end
        else if (low_byte)
        begin
            phase_next = 1'b0;
            if (col_end)
            begin
                col_next     = '0;
                col_acc_next = '0;
                col_c_next   = '0;
                if (row_end)
                begin
                    row_next     = '0;
                    row_acc_next = '0;
                    row_c_next   = '0;
                end
                else
                begin
                    row_next     = row_reg + RW'(1);
                    row_acc_next = RW'(row_acc_step);
                    row_c_next   = row_c_step;
                end
            end
            else
            begin
                col_next     = col_reg + CW'(1);
                col_acc_next = CW'(col_acc_step);
                col_c_next   = col_c_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= 1'b0;
            high_reg    <= '0;
            col_reg     <= '0;
            col_acc_reg <= '0;
            col_c_reg   <= '0;
            row_reg     <= '0;
            row_acc_reg <= '0;
            row_c_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            high_reg    <= high_next;
            col_reg     <= col_next;
            col_acc_reg <= col_acc_next;
            col_c_reg   <= col_c_next;
            row_reg     <= row_next;
            row_acc_reg <= row_acc_next;
            row_c_reg   <= row_c_next;
        end
    end

endmodule

>>> src/rgbg_queue.sv
// Short item queue between the front end and the back end.
// Depends on rgbg_pkg.
module rgbg_queue #(
    parameter int DEPTH = 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  rgbg_pkg::sample_t         push_item,
    input  logic                      pop,
    output rgbg_pkg::sample_t         head,
    output rgbg_pkg::queue_status_t   status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    rgbg_pkg::sample_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    assign status.full  = (count_reg == NW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + NW'(1);
        else if (pop && !push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> src/rgbg_back.sv
// Back end: weighted gray sum, divide by 1000, output register.
// Depends on rgbg_pkg.
module rgbg_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  rgbg_pkg::sample_t                   item,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rgbg_pkg::GRAY_W-1:0]         gray,
    output logic [rgbg_pkg::COORD_W-1:0]        dest_x,
    output logic [rgbg_pkg::COORD_W-1:0]        dest_y,
    output logic                                last_of_frame
);

    logic                               s1_valid_reg;
    logic [rgbg_pkg::SUM_W-1:0]         s1_sum_reg;
    logic [rgbg_pkg::COORD_W-1:0]       s1_x_reg, s1_y_reg;
    logic                               s1_last_reg;
    logic                               out_valid_reg;
    logic [rgbg_pkg::GRAY_W-1:0]        gray_reg;
    logic [rgbg_pkg::COORD_W-1:0]       x_reg, y_reg;
    logic                               last_reg;

    logic [4:0]                         r;
    logic [5:0]                         g;
    logic [4:0]                         b;
    logic [rgbg_pkg::SUM_W-1:0]         sum;
    logic [rgbg_pkg::PROD_W-1:0]        prod;
    logic                               s2_load, s1_load;

    assign r = item.pixel[15:11];
    assign g = item.pixel[10:5];
    assign b = item.pixel[4:0];
    assign sum = rgbg_pkg::SUM_W'(r) * rgbg_pkg::R_WEIGHT
               + rgbg_pkg::SUM_W'(g) * rgbg_pkg::G_WEIGHT
               + rgbg_pkg::SUM_W'(b) * rgbg_pkg::B_WEIGHT;
    assign prod = rgbg_pkg::PROD_W'(s1_sum_reg) * rgbg_pkg::PROD_W'(rgbg_pkg::RECIP);

    assign s2_load = !out_valid_reg || out_ready;
    assign s1_load = !s1_valid_reg || s2_load;
    assign pop     = item_valid && s1_load;

    assign out_valid     = out_valid_reg;
    assign gray          = gray_reg;
    assign dest_x        = x_reg;
    assign dest_y        = y_reg;
    assign last_of_frame = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= item_valid;
            if (s2_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_sum_reg  <= sum;
            s1_x_reg    <= item.dest_x;
            s1_y_reg    <= item.dest_y;
            s1_last_reg <= item.last;
        end
        if (s2_load && s1_valid_reg)
        begin
            gray_reg <= prod[rgbg_pkg::RECIP_SHIFT +: rgbg_pkg::GRAY_W];
            x_reg    <= s1_x_reg;
            y_reg    <= s1_y_reg;
            last_reg <= s1_last_reg;
        end
    end

endmodule

>>> src/rgb565_gray_nearest_downscale_unit.sv
// Throughput: one byte per cycle unless stalled; a kept two-byte pixel yields one item.
// A result passes from the queue through the sum stage register into the output register.
// The byte input stalls only when the two-entry queue is full (back end held by out_ready).
// Reset (rst_n, async, active low) clears byte phase, counters, queue and valids;
// the next byte is taken as the high byte of pixel (0,0) of a new frame.
// Depends on rgbg_pkg, rgbg_front, rgbg_queue, rgbg_back.
module rgb565_gray_nearest_downscale_unit #(
    parameter int SRC_WIDTH  = 160,
    parameter int SRC_HEIGHT = 120,
    parameter int DST_WIDTH  = 24,
    parameter int DST_HEIGHT = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          pixel_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rgbg_pkg::GRAY_W-1:0]         gray,
    output logic [rgbg_pkg::COORD_W-1:0]        dest_x,
    output logic [rgbg_pkg::COORD_W-1:0]        dest_y,
    output logic                                last_of_frame
);

    logic                       accept;
    logic                       push;
    logic                       pop;
    rgbg_pkg::sample_t          push_item;
    rgbg_pkg::sample_t          head;
    rgbg_pkg::queue_status_t    q_status;

    // The front end only needs queue room; it never waits on the output side directly
    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // Byte pairing, source position tracking and sampling decision
    rgbg_front #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .DST_WIDTH  (DST_WIDTH),
        .DST_HEIGHT (DST_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .pixel_byte (pixel_byte),
        .push       (push),
        .item       (push_item)
    );

    // Decouples the byte stream from output backpressure
    rgbg_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // Gray arithmetic: sum stage, reciprocal-multiply stage into the output register
    rgbg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (!q_status.empty),
        .item          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .gray          (gray),
        .dest_x        (dest_x),
        .dest_y        (dest_y),
        .last_of_frame (last_of_frame)
    );

    // Checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue read while empty");

    a_gray_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gray <= rgbg_pkg::GRAY_MAX)
        else $error("gray value out of range");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb565_gray_nearest_downscale_unit.
// Needs only the RTL: rgbg_pkg and the top level with its submodules.
module tb_top;

    // Default geometry: 160x120 source, 24x24 destination
    localparam int SRC_W = 160;
    localparam int SRC_H = 120;
    localparam int DST_W = 24;
    localparam int DST_H = 24;
    localparam int HOLD_CYCLES = 400;   // long output stall for the backpressure test
    localparam int DRAIN_CYCLES = 8;    // extra wait after the last expected sample is taken
    localparam int GAPLESS_END_COL = 80;    // gap-free run covers row 0 up to this column
    localparam int RANDOM_BYTES = 430;      // random traffic after row 0

    // One downscaled gray sample as seen on the output ports
    typedef struct {
        logic [rgbg_pkg::GRAY_W-1:0]  gray;
        logic [rgbg_pkg::COORD_W-1:0] dest_x;
        logic [rgbg_pkg::COORD_W-1:0] dest_y;
        logic                         last;
    } gray_sample_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [7:0]                   pixel_byte = 8'h00;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [rgbg_pkg::GRAY_W-1:0]  gray;
    logic [rgbg_pkg::COORD_W-1:0] dest_x;
    logic [rgbg_pkg::COORD_W-1:0] dest_y;
    logic                         last_of_frame;

    // Shared run state
    gray_sample_t expected_samples[$];
    int  error_count = 0;
    int  bytes_sent = 0;
    int  samples_checked = 0;
    bit  gaps_enabled = 1'b1;   // random idle cycles on both sides
    bit  hold_request = 1'b0;   // asks the receiver for one long stall

    // Predictor state: mirrors the pixel assembler and the sampling counters
    logic [7:0] held_high;
    bit         low_phase;
    int         src_col;
    int         src_row;
    int         want_col;
    int         want_row;

    rgb565_gray_nearest_downscale_unit #(
        .SRC_WIDTH (SRC_W),
        .SRC_HEIGHT(SRC_H),
        .DST_WIDTH (DST_W),
        .DST_HEIGHT(DST_H)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_byte   (pixel_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .gray         (gray),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .last_of_frame(last_of_frame)
    );

    always #2 clk = ~clk;

    // Source index that destination index d samples
    function automatic int sampled_source(int d, int src, int dst);
        return (d * src) / dst;
    endfunction

    // Smallest destination index sampling past source index s, capped at dst
    function automatic int next_dest_index(int s, int src, int dst);
        int n;
        n = ((s + 1) * dst + src - 1) / src;
        return (n > dst) ? dst : n;
    endfunction

    // Camera byte biased toward the all-zero and all-one extremes
    function automatic logic [7:0] camera_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void clear_tracker();
        held_high = 8'h00;
        low_phase = 1'b0;
        src_col = 0;
        src_row = 0;
        want_col = 0;
        want_row = 0;
    endfunction

    // Advance the predictor by one accepted byte; queue a sample when a pixel is kept
    function automatic void track_camera_byte(logic [7:0] b);
        logic [15:0]  pixel;
        int           r, g, bl, luma, nc, nr;
        bit           row_hit, col_hit;
        gray_sample_t s;
        if (!low_phase) begin
            held_high = b;
            low_phase = 1'b1;
            return;
        end
        low_phase = 1'b0;
        pixel = {held_high, b};
        r  = pixel[15:11];
        g  = pixel[10:5];
        bl = pixel[4:0];
        luma = (r * 299 + g * 587 + bl * 114) / 1000;
        row_hit = (want_row < DST_H) && (sampled_source(want_row, SRC_H, DST_H) == src_row);
        col_hit = (want_col < DST_W) && (sampled_source(want_col, SRC_W, DST_W) == src_col);
        if (row_hit && col_hit) begin
            nc = next_dest_index(src_col, SRC_W, DST_W);
            nr = next_dest_index(src_row, SRC_H, DST_H);
            s.gray   = rgbg_pkg::GRAY_W'(luma);
            s.dest_x = rgbg_pkg::COORD_W'(want_col);
            s.dest_y = rgbg_pkg::COORD_W'(want_row);
            s.last   = (nc >= DST_W) && (nr >= DST_H);
            expected_samples.push_back(s);
            want_col = nc;
        end
        // end of a source row: rewind the column, step the row, wrap at frame end
        if (src_col + 1 >= SRC_W) begin
            src_col = 0;
            want_col = 0;
            if (row_hit)
                want_row = next_dest_index(src_row, SRC_H, DST_H);
            if (src_row + 1 >= SRC_H) begin
                src_row = 0;
                want_row = 0;
            end else begin
                src_row = src_row + 1;
            end
        end else begin
            src_col = src_col + 1;
        end
    endfunction

    // Offer one byte, hold it until accepted, then update the prediction
    task automatic send_byte(input logic [7:0] b);
        if (gaps_enabled && $urandom_range(0, 99) < 33) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pixel_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        track_camera_byte(b);
    endtask

    task automatic send_pixel(input logic [15:0] p);
        send_byte(p[15:8]);
        send_byte(p[7:0]);
    endtask

    // Row 0 start: extreme channel values; pixels 0 and 6 are sampled
    task automatic test_extremes();
        logic [15:0] pix [12] = '{16'hFFFF, 16'hF800, 16'h07E0, 16'h001F,
                                  16'h8410, 16'h7BEF, 16'h0000, 16'hFFE0,
                                  16'h07FF, 16'hF81F, 16'h0821, 16'hFFFE};
        foreach (pix[i])
            send_pixel(pix[i]);
    endtask

    // Middle of row 0 with no idle cycles on either side
    task automatic test_gapless_run();
        gaps_enabled = 1'b0;
        while (src_col < GAPLESS_END_COL || low_phase)
            send_byte(camera_byte());
        gaps_enabled = 1'b1;
    endtask

    // Rest of sampled row 0 with the output held off for a long stretch:
    // the small output queue fills and the byte input must stall
    task automatic test_backpressure();
        gaps_enabled = 1'b0;
        hold_request = 1'b1;
        do
            send_byte(camera_byte());
        while (src_col != 0 || low_phase);
        gaps_enabled = 1'b1;
    endtask

    // Random bytes with idling on both sides through the next rows
    task automatic test_random_rows();
        repeat (RANDOM_BYTES)
            send_byte(camera_byte());
    endtask

    // Receiver: random ready, with one long stall on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (gaps_enabled) begin
                out_ready <= ($urandom_range(0, 99) >= 33);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Output check: each accepted sample against the oldest prediction
    always @(posedge clk) begin
        gray_sample_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_samples.size() == 0) begin
                error_count++;
                $display("%0t: unexpected sample gray=%0d x=%0d y=%0d last=%0b",
                         $time, gray, dest_x, dest_y, last_of_frame);
            end else begin
                want = expected_samples.pop_front();
                samples_checked++;
                if (gray !== want.gray) begin
                    error_count++;
                    $display("%0t: gray mismatch, expected %0d actual %0d",
                             $time, want.gray, gray);
                end
                if (dest_x !== want.dest_x) begin
                    error_count++;
                    $display("%0t: dest_x mismatch, expected %0d actual %0d",
                             $time, want.dest_x, dest_x);
                end
                if (dest_y !== want.dest_y) begin
                    error_count++;
                    $display("%0t: dest_y mismatch, expected %0d actual %0d",
                             $time, want.dest_y, dest_y);
                end
                if (last_of_frame !== want.last) begin
                    error_count++;
                    $display("%0t: last_of_frame mismatch, expected %0b actual %0b",
                             $time, want.last, last_of_frame);
                end
            end
        end
    end

    // Watchdog: many times the slowest legal run
    initial begin
        #400_000;
        $display("%0t: timeout with %0d samples outstanding", $time,
                 expected_samples.size());
        $display("rgb565_gray_nearest_downscale_unit test failed");
        $finish;
    end

    initial begin
        clear_tracker();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_gapless_run();
        test_backpressure();
        test_random_rows();

        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d camera bytes up to source row %0d: extreme pixels, a gap-free run,",
                 bytes_sent, src_row);
        $display("a long output stall and random idling; %0d gray samples checked.",
                 samples_checked);
        if (error_count == 0)
            $display("rgb565_gray_nearest_downscale_unit test passed");
        else
            $display("rgb565_gray_nearest_downscale_unit test failed");
        $finish;
    end

endmodule
